@@ rtl/core/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap queue core.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // Default sizes of the heap store.
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 32;

    // Fixed widths of the item fields on the stream ports.
    localparam int KEY_FIELD_W  = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;

    // Configuration port.
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic REG_KEY_SIGNED = 1'b0;

    // Operation carried in the input tuser.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_REMOVED  = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LD,
        ST_DN_RD,
        ST_DN_SEL,
        ST_DN_CMP,
        ST_FIN
    } t_state;

endpackage

@@ rtl/core/bmhq_ram.sv @@
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

@@ rtl/core/bmhq_key_cmp.sv @@
// ----------------------------------------------------------------------------
// bmhq_key_cmp
// Shared key comparator: a less than b, unsigned or two's complement.
// ----------------------------------------------------------------------------
module bmhq_key_cmp #(
    parameter int W = 32
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_signed,
    output logic         o_less
);

    logic [W-1:0] w_flip;
    logic [W-1:0] w_a;
    logic [W-1:0] w_b;

    // Flipping the sign bit maps two's complement order onto unsigned order.
    assign w_flip = {i_signed, {(W-1){1'b0}}};
    assign w_a    = i_a ^ w_flip;
    assign w_b    = i_b ^ w_flip;
    assign o_less = (w_a < w_b);

endmodule

@@ rtl/core/binary_min_heap_queue_core.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Binary min-heap priority queue of keys held in an on-chip RAM.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+--------------------------------
//  s        | in        | i_s_tvalid/o_s_tready | tuser: kind, tdata: key
//  m        | out       | o_m_tvalid/i_m_tready | tuser: status, tdata: key,count
//  apb      | in        | psel/penable, pready  | register key_signed
//
//  An insert lets the new key climb L levels, where L is at most
//  log2(CAPACITY), until its parent is not greater or it reaches the root.
//  A remove returns the root, moves the last key to the root and lets it
//  sink L levels, down to a leaf or until it stops above one.
//  Each level needs one registered RAM read and one or two passes through
//  the single comparator. Refused inserts and removes from an empty heap
//  go straight to their result.
//  Reset is synchronous and active low; it empties the heap and clears
//  key_signed. The RAM contents are not cleared, since slots beyond the
//  count are never read. A stalled result waits in the output register
//  while the next item is accepted; that item then holds in its final step.
//
module binary_min_heap_queue_core
    import bmhq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input item stream.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,  // [31:0] key
    input  logic                   i_s_tuser,  // [0] kind
    // Result item stream.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,  // [31:0] out_key, [38:32] count, pad
    output logic [STATUS_W-1:0]    o_m_tuser,  // [1:0] status
    // Configuration port.
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [APB_ADDR_W-1:0]  i_paddr,
    input  logic [APB_DATA_W-1:0]  i_pwdata,
    output logic [APB_DATA_W-1:0]  o_prdata,
    output logic                   o_pready
);

    // Count and slot index width; slot 0 of the RAM is unused (root at 1).
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = CAPACITY + 1;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_pos, n_pos;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [KEY_WIDTH-1:0]  r_pick, n_pick;
    logic [CW-1:0]         r_pick_idx, n_pick_idx;
    logic [KEY_WIDTH-1:0]  r_res, n_res;
    t_status               r_status, n_status;
    logic                  r_key_signed;
    logic                  r_out_valid, n_out_valid;
    logic [KEY_FIELD_W-1:0] r_out_key, n_out_key;
    t_status               r_out_status, n_out_status;
    logic [COUNT_W-1:0]    r_out_cnt, n_out_cnt;

    logic                  w_in_acc;
    logic [KEY_WIDTH-1:0]  w_key_in;
    logic [KEY_FIELD_W-1:0] w_res_out;
    logic [COUNT_W-1:0]    w_cnt_out;

    // RAM ports.
    logic                  w_we;
    logic [CW-1:0]         w_waddr;
    logic [KEY_WIDTH-1:0]  w_wdata;
    logic [CW-1:0]         w_raddr0;
    logic [CW-1:0]         w_raddr1;
    logic [KEY_WIDTH-1:0]  w_rdata0;
    logic [KEY_WIDTH-1:0]  w_rdata1;

    // Comparator operands.
    logic [KEY_WIDTH-1:0]  w_cmp_a;
    logic [KEY_WIDTH-1:0]  w_cmp_b;
    logic                  w_less;

    // Children of the current slot during the descent.
    logic [CW:0]           w_child;
    logic [CW:0]           w_child_r;
    logic                  w_has_l;
    logic                  w_has_r;

    logic                  w_cfg_wr;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);

    assign w_child   = {r_pos, 1'b0};
    assign w_child_r = w_child + (CW+1)'(1);
    assign w_has_l   = (w_child <= {1'b0, r_cnt});
    assign w_has_r   = (w_child_r <= {1'b0, r_cnt});

    // Width adaptation between the fixed field widths and the parameters.
    generate
        if (KEY_WIDTH > KEY_FIELD_W) begin : g_key_wide
            assign w_key_in  = {{(KEY_WIDTH-KEY_FIELD_W){1'b0}}, i_s_tdata[KEY_FIELD_W-1:0]};
            assign w_res_out = r_res[KEY_FIELD_W-1:0];
        end else if (KEY_WIDTH == KEY_FIELD_W) begin : g_key_same
            assign w_key_in  = i_s_tdata[KEY_FIELD_W-1:0];
            assign w_res_out = r_res;
        end else begin : g_key_narrow
            assign w_key_in  = i_s_tdata[KEY_WIDTH-1:0];
            assign w_res_out = {{(KEY_FIELD_W-KEY_WIDTH){1'b0}}, r_res};
        end
        if (CW > COUNT_W) begin : g_cnt_wide
            assign w_cnt_out = r_cnt[COUNT_W-1:0];
        end else if (CW == COUNT_W) begin : g_cnt_same
            assign w_cnt_out = r_cnt;
        end else begin : g_cnt_narrow
            assign w_cnt_out = {{(COUNT_W-CW){1'b0}}, r_cnt};
        end
    endgenerate

    bmhq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH),
        .AW    (CW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0),
        .o_rdata1 (w_rdata1)
    );

    // The one comparator is steered by the sequencer state: the climbing key
    // against its parent, the right child against the left, or the chosen
    // child against the key that sinks.
    always_comb begin
        unique case (r_state)
            ST_DN_SEL: begin
                w_cmp_a = w_rdata1;
                w_cmp_b = w_rdata0;
            end
            ST_DN_CMP: begin
                w_cmp_a = r_pick;
                w_cmp_b = r_key;
            end
            default: begin
                w_cmp_a = r_key;
                w_cmp_b = w_rdata0;
            end
        endcase
    end

    bmhq_key_cmp #(
        .W (KEY_WIDTH)
    ) u_cmp (
        .i_a      (w_cmp_a),
        .i_b      (w_cmp_b),
        .i_signed (r_key_signed),
        .o_less   (w_less)
    );

    // RAM read addresses. On an idle cycle the root and the last slot are
    // read so that a remove finds both ready in the cycle after acceptance.
    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                w_raddr0 = CW'(1);
                w_raddr1 = r_cnt;
            end
            ST_UP_RD: begin
                w_raddr0 = r_pos >> 1;
                w_raddr1 = r_pos >> 1;
            end
            ST_DN_RD: begin
                w_raddr0 = w_has_l ? w_child[CW-1:0] : r_pos;
                w_raddr1 = w_has_r ? w_child_r[CW-1:0] : w_raddr0;
            end
            default: begin
                w_raddr0 = r_pos;
                w_raddr1 = r_pos;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_key        = r_key;
        n_pick       = r_pick;
        n_pick_idx   = r_pick_idx;
        n_res        = r_res;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;
        n_out_cnt    = r_out_cnt;
        w_we         = 1'b0;
        w_waddr      = r_pos;
        w_wdata      = r_key;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_res = '0;
                    if (i_s_tuser == KIND_INSERT) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_status = STAT_FULL;
                            n_state  = ST_FIN;
                        end else begin
                            n_status = STAT_INSERTED;
                            n_cnt    = r_cnt + CW'(1);
                            n_pos    = r_cnt + CW'(1);
                            n_key    = w_key_in;
                            n_state  = ST_UP_RD;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = STAT_EMPTY;
                            n_state  = ST_FIN;
                        end else begin
                            n_status = STAT_REMOVED;
                            n_state  = ST_DN_LD;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                // At the root the key settles; otherwise its parent is read.
                if (r_pos == CW'(1)) begin
                    w_we    = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                w_we = 1'b1;
                if (w_less) begin
                    // Parent moves down into the hole; the key climbs.
                    w_wdata = w_rdata0;
                    n_pos   = r_pos >> 1;
                    n_state = ST_UP_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DN_LD: begin
                n_res   = w_rdata0;
                n_key   = w_rdata1;
                n_cnt   = r_cnt - CW'(1);
                n_pos   = CW'(1);
                n_state = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (!w_has_l) begin
                    w_we    = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_DN_SEL;
                end
            end
            ST_DN_SEL: begin
                // Equal children favor the left one.
                if (w_has_r && w_less) begin
                    n_pick     = w_rdata1;
                    n_pick_idx = w_child_r[CW-1:0];
                end else begin
                    n_pick     = w_rdata0;
                    n_pick_idx = w_child[CW-1:0];
                end
                n_state = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                w_we = 1'b1;
                if (w_less) begin
                    w_wdata = r_pick;
                    n_pos   = r_pick_idx;
                    n_state = ST_DN_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = w_res_out;
                    n_out_status = r_status;
                    n_out_cnt    = w_cnt_out;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_pick       <= n_pick;
        r_pick_idx   <= n_pick_idx;
        r_res        <= n_res;
        r_status     <= n_status;
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
        r_out_cnt    <= n_out_cnt;
    end

    // Configuration register. Only bit 0 of the written value is kept.
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_signed <= 1'b0;
        end else if (w_cfg_wr && (i_paddr[2] == REG_KEY_SIGNED)) begin
            r_key_signed <= i_pwdata[0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_KEY_SIGNED) ?
                      {{(APB_DATA_W-1){1'b0}}, r_key_signed} : '0;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-KEY_FIELD_W-COUNT_W){1'b0}}, r_out_cnt, r_out_key};
    assign o_m_tuser  = r_out_status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // While a key climbs, its slot lies inside the held part of the heap.
    a_up_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UP_RD || r_state == ST_UP_CMP) |-> (r_pos != '0 && r_pos <= r_cnt))
        else $error("sift-up slot outside the held keys");

    // Slot 0 is never written: the root sits at slot 1.
    a_no_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_waddr != '0))
        else $error("write to unused slot 0");

    // An insert into a full heap is refused and goes straight to its result.
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tuser == KIND_INSERT && r_cnt == CW'(CAPACITY))
        |=> (r_state == ST_FIN && r_status == STAT_FULL && r_cnt == CW'(CAPACITY)))
        else $error("insert into full heap not refused");

    // A remove from an empty heap reports a zero key and a zero count.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == STAT_EMPTY)
        |-> (o_m_tdata[KEY_FIELD_W-1:0] == '0 &&
             o_m_tdata[KEY_FIELD_W+COUNT_W-1:KEY_FIELD_W] == '0))
        else $error("empty result carries a key or a count");

endmodule
